>>> hw/rtl/apbc_pkg.sv
`timescale 1ns / 1ps

package apbc_pkg;

  // Limits and scales of the controller
  localparam int unsigned StallLimit = 100;
  localparam int unsigned LoadScale  = 10000;
  localparam int unsigned CutShift   = 3;      // burst cut by one eighth
  localparam int unsigned CeilMin    = 10;
  localparam int unsigned CeilMax    = 1000;
  localparam int unsigned RateMax    = 30000;
  localparam int unsigned PctMax     = 100;

  // Field widths
  localparam int unsigned BurstW   = 10;
  localparam int unsigned ShareW   = 7;
  localparam int unsigned PeriodW  = 15;
  localparam int unsigned CountW   = 16;
  localparam int unsigned PendW    = 7;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CntW     = 32;
  localparam int unsigned ElapsedW = 20;
  localparam int unsigned ProdW    = ElapsedW + PeriodW;
  localparam int unsigned LimW     = 21;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  // Register reset values
  localparam logic [BurstW-1:0]  CeilRst   = 10'd150;
  localparam logic [BurstW-1:0]  ChunkRst  = 10'd5;
  localparam logic [ShareW-1:0]  ShareRst  = 7'd50;
  localparam logic [PeriodW-1:0] PeriodRst = 15'd20;
  localparam logic [PeriodW-1:0] RateRst   = 15'd2000;
  localparam logic [BurstW-1:0]  BurstRst  = 10'd5;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CEILING = 3'd0,
    CFG_CHUNK   = 3'd1,
    CFG_SHARE   = 3'd2,
    CFG_PERIOD  = 3'd3,
    CFG_RATE    = 3'd4,
    CFG_ENABLE  = 3'd5
  } cfg_idx_e;

  // Event kinds carried in tuser
  typedef enum logic [1:0] {
    EV_TICK      = 2'd0,
    EV_POLL_RUN  = 2'd1,
    EV_POLL_DONE = 2'd2
  } ev_kind_e;

  // Controller phases
  typedef enum logic [PhaseW-1:0] {
    PH_IDLE    = 3'd0,
    PH_TICKED  = 3'd2,
    PH_RUNNING = 3'd4,
    PH_DONE    = 3'd5,
    PH_REPOLL  = 3'd6
  } phase_e;

  // Effective configuration seen by the core
  typedef struct packed {
    logic [BurstW-1:0]  ceil_eff;
    logic [BurstW-1:0]  chunk_eff;
    logic [LimW-1:0]    load_lim;   // product at or above this means overload
    logic [PeriodW-1:0] period;
    logic [PeriodW-1:0] rate;
    logic               enable;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic              start_poll;
    logic [BurstW-1:0] poll_count;
    logic              check_status;
    logic              release_all;
    logic [BurstW-1:0] burst_now;
    logic [PhaseW-1:0] phase_now;
    logic [CntW-1:0]   lost_ticks;
    logic [CntW-1:0]   stall_count;
    logic [CntW-1:0]   suspect_count;
  } res_t;

  // Smallest elapsed*rate product whose load (product / LoadScale) exceeds
  // the share left to polling.
  function automatic logic [LimW-1:0] load_limit(input logic [ShareW-1:0] share);
    logic [ShareW-1:0] s;
    logic [ShareW-1:0] left;
    begin
      s    = (share > ShareW'(PctMax)) ? ShareW'(PctMax) : share;
      left = ShareW'(PctMax + 1) - s;
      load_limit = LimW'(left) * LimW'(LoadScale);
    end
  endfunction

endpackage

>>> hw/rtl/adaptive_poll_burst_controller.sv
`timescale 1ns / 1ps

// Adaptive poll-burst controller.
// Input channel s_axis: one beat per event. tuser holds the event kind
// (tick, poll run, poll done); tdata holds elapsed_us and have_devices.
// Output channel m_axis: exactly one result beat per input beat, in order,
// carrying the poll request, the chunk to hand out, status and release
// flags, the burst, the phase and the three event counters.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (ceiling, chunk, user share, status period, poll rate, enable) at the
// clock edge; write only while no event is in flight.
// An accepted beat is registered in the input register, is processed by
// the core and lands in the output register once that register is free.
// Throughput is one event per cycle while m_axis_tready stays high;
// the elapsed*rate product is formed on the way into the input register
// and the core computes the state update combinationally.
// Reset (rst_ni low) restores the register defaults and clears the core state and both valid flags.
// When m_axis_tready is low the output register holds its beat, one more
// event may wait in the input register, then s_axis_tready drops.
module adaptive_poll_burst_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // elapsed_us[19:0], have_devices[20], zero
  input  logic [1:0]                    s_axis_tuser,  // mode[1:0]

  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [127:0]                  m_axis_tdata,  // start_poll[0], poll_count[10:1],
                                                       // check_status[11], release_all[12],
                                                       // burst_now[22:13], phase_now[25:23],
                                                       // lost_ticks[57:26], stall_count[89:58],
                                                       // suspect_count[121:90], zero

  input  logic                          cfg_we_i,
  input  logic [apbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [apbc_pkg::CfgDataW-1:0] cfg_data_i
);

  apbc_pkg::cfg_t cfg;
  apbc_pkg::res_t res, out_q;

  logic                        in_valid_q, out_valid_q;
  logic [1:0]                  in_mode_q;
  logic                        in_have_q;
  logic [apbc_pkg::ProdW-1:0]  in_prod_q;
  logic                        out_ready, advance, s_accept;

  apbc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: output register frees when empty or taken
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Input register with the load product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_mode_q <= s_axis_tuser;
      in_have_q <= s_axis_tdata[apbc_pkg::ElapsedW];
      in_prod_q <= apbc_pkg::ProdW'(s_axis_tdata[apbc_pkg::ElapsedW-1:0])
                 * apbc_pkg::ProdW'(cfg.rate);
    end
  end

  apbc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .mode_i    (in_mode_q),
    .have_i    (in_have_q),
    .prod_i    (in_prod_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0,
                          out_q.suspect_count,
                          out_q.stall_count,
                          out_q.lost_ticks,
                          out_q.phase_now,
                          out_q.burst_now,
                          out_q.release_all,
                          out_q.check_status,
                          out_q.poll_count,
                          out_q.start_poll};

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q) else $error("committed event left no result");
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_ready) |=> in_valid_q && $stable(in_prod_q))
    else $error("held event lost while output stalled");

endmodule

>>> hw/rtl/apbc_cfg.sv
`timescale 1ns / 1ps

module apbc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [apbc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [apbc_pkg::CfgDataW-1:0]  cfg_data_i,
  output apbc_pkg::cfg_t                 cfg_o
);

  logic [apbc_pkg::BurstW-1:0]  ceil_q, chunk_q;
  logic [apbc_pkg::ShareW-1:0]  share_q;
  logic [apbc_pkg::PeriodW-1:0] period_q, rate_q;
  logic                         enable_q;

  logic [apbc_pkg::PeriodW-1:0] wr_val, period_wr, rate_wr;
  logic [apbc_pkg::BurstW-1:0]  ceil_eff;

  // Saturate incoming period and rate values
  always_comb begin
    wr_val    = cfg_data_i[apbc_pkg::PeriodW-1:0];
    period_wr = (wr_val > rate_q) ? rate_q : wr_val;
    if (period_wr == '0) period_wr = apbc_pkg::PeriodW'(1);
    rate_wr = wr_val;
    if (rate_wr == '0) rate_wr = apbc_pkg::PeriodW'(1);
    if (rate_wr > apbc_pkg::PeriodW'(apbc_pkg::RateMax))
      rate_wr = apbc_pkg::PeriodW'(apbc_pkg::RateMax);
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q   <= apbc_pkg::CeilRst;
      chunk_q  <= apbc_pkg::ChunkRst;
      share_q  <= apbc_pkg::ShareRst;
      period_q <= apbc_pkg::PeriodRst;
      rate_q   <= apbc_pkg::RateRst;
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        apbc_pkg::CFG_CEILING: ceil_q   <= cfg_data_i[apbc_pkg::BurstW-1:0];
        apbc_pkg::CFG_CHUNK:   chunk_q  <= cfg_data_i[apbc_pkg::BurstW-1:0];
        apbc_pkg::CFG_SHARE:   share_q  <= cfg_data_i[apbc_pkg::ShareW-1:0];
        apbc_pkg::CFG_PERIOD:  period_q <= period_wr;
        apbc_pkg::CFG_RATE: begin
          rate_q <= rate_wr;
          if (period_q > rate_wr) period_q <= rate_wr;
        end
        apbc_pkg::CFG_ENABLE:  enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp ceiling and chunk, derive the overload threshold
  always_comb begin
    ceil_eff = ceil_q;
    if (ceil_q < apbc_pkg::BurstW'(apbc_pkg::CeilMin))
      ceil_eff = apbc_pkg::BurstW'(apbc_pkg::CeilMin);
    else if (ceil_q > apbc_pkg::BurstW'(apbc_pkg::CeilMax))
      ceil_eff = apbc_pkg::BurstW'(apbc_pkg::CeilMax);

    cfg_o.ceil_eff = ceil_eff;
    if (chunk_q == '0)         cfg_o.chunk_eff = apbc_pkg::BurstW'(1);
    else if (chunk_q > ceil_eff) cfg_o.chunk_eff = ceil_eff;
    else                       cfg_o.chunk_eff = chunk_q;
    cfg_o.load_lim = apbc_pkg::load_limit(share_q);
    cfg_o.period   = period_q;
    cfg_o.rate     = rate_q;
    cfg_o.enable   = enable_q;
  end

  a_period_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    period_q != '0) else $error("status period is zero");
  a_period_le_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    period_q <= rate_q) else $error("status period above poll rate");
  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_q != '0 && rate_q <= apbc_pkg::PeriodW'(apbc_pkg::RateMax))
    else $error("poll rate out of range");

endmodule

>>> hw/rtl/apbc_core.sv
`timescale 1ns / 1ps

module apbc_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,   // commit the held event
  input  logic [1:0]                   mode_i,
  input  logic                         have_i,
  input  logic [apbc_pkg::ProdW-1:0]   prod_i,      // elapsed_us * poll_rate
  input  apbc_pkg::cfg_t               cfg_i,
  output apbc_pkg::res_t               res_o
);

  logic [apbc_pkg::BurstW-1:0] burst_q, burst_d;
  logic [apbc_pkg::BurstW-1:0] resid_q, resid_d;
  logic [apbc_pkg::CountW-1:0] cd_q, cd_d, cd_eff;
  logic [apbc_pkg::PendW-1:0]  pend_q, pend_d;
  apbc_pkg::phase_e            phase_q, phase_d;
  logic                        queued_q, queued_d;
  logic [apbc_pkg::CntW-1:0]   lost_q, lost_d, stall_q, stall_d, susp_q, susp_d;

  logic                        start, check, release_s, status;
  logic [apbc_pkg::BurstW-1:0] count, res_base, cyc, b1;
  logic [apbc_pkg::CountW-1:0] period_w;

  // Pull the countdown under a freshly lowered status period
  assign period_w = apbc_pkg::CountW'(cfg_i.period);
  assign cd_eff   = (cd_q > period_w) ? period_w - apbc_pkg::CountW'(1) : cd_q;

  // Event update
  always_comb begin
    burst_d   = burst_q;
    resid_d   = resid_q;
    cd_d      = cd_eff;
    pend_d    = pend_q;
    phase_d   = phase_q;
    queued_d  = queued_q;
    lost_d    = lost_q;
    stall_d   = stall_q;
    susp_d    = susp_q;
    start     = 1'b0;
    count     = '0;
    check     = 1'b0;
    release_s = 1'b0;
    status    = 1'b0;
    res_base  = resid_q;
    cyc       = '0;
    b1        = burst_q;

    case (mode_i)
      apbc_pkg::EV_TICK: begin
        if (have_i) begin
          if (pend_d > apbc_pkg::PendW'(apbc_pkg::StallLimit)) begin
            stall_d = stall_q + 1'b1;
            pend_d  = '0;
            phase_d = apbc_pkg::PH_IDLE;
          end
          if (phase_d inside {apbc_pkg::PH_IDLE, apbc_pkg::PH_TICKED}) begin
            if (phase_d != apbc_pkg::PH_IDLE) susp_d = susp_q + 1'b1;
            start    = !queued_q;
            queued_d = 1'b1;
            phase_d  = apbc_pkg::PH_TICKED;
          end
          if (pend_d != '0) lost_d = lost_q + 1'b1;
          pend_d = pend_d + 1'b1;
        end
      end

      apbc_pkg::EV_POLL_RUN: begin
        queued_d = 1'b0;
        // Load a fresh budget at the first run of a tick
        if (resid_q == '0) begin
          if (cd_eff == '0) begin
            status = 1'b1;
            cd_d   = period_w - apbc_pkg::CountW'(1);
          end else begin
            cd_d = cd_eff - apbc_pkg::CountW'(1);
          end
          res_base = burst_q;
        end
        cyc     = (res_base < cfg_i.chunk_eff) ? res_base : cfg_i.chunk_eff;
        resid_d = res_base - cyc;
        if (cfg_i.enable) begin
          count = cyc;
          check = status;
        end else begin
          release_s = 1'b1;
          resid_d   = '0;
        end
        phase_d = apbc_pkg::PH_RUNNING;
      end

      apbc_pkg::EV_POLL_DONE: begin
        phase_d = apbc_pkg::PH_DONE;
        if (resid_q != '0) begin
          start    = !queued_q;
          queued_d = 1'b1;
        end else begin
          // Step the burst against the measured load
          if (prod_i >= apbc_pkg::ProdW'(cfg_i.load_lim)) begin
            if (burst_q > apbc_pkg::BurstW'(1)) b1 = burst_q - 1'b1;
          end else begin
            if (burst_q < cfg_i.ceil_eff) b1 = burst_q + 1'b1;
          end
          burst_d = b1;
          if (pend_q != '0) pend_d = pend_q - 1'b1;
          if (pend_d == '0) begin
            phase_d = apbc_pkg::PH_IDLE;
          end else begin
            // Missed ticks: cut the burst and poll again
            burst_d  = b1 - (b1 >> apbc_pkg::CutShift);
            start    = !queued_q;
            queued_d = 1'b1;
            phase_d  = apbc_pkg::PH_REPOLL;
          end
        end
      end

      default: ;
    endcase
  end

  // Commit state on advance; otherwise only the countdown follows the period
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q  <= apbc_pkg::BurstRst;
      resid_q  <= '0;
      cd_q     <= '0;
      pend_q   <= '0;
      phase_q  <= apbc_pkg::PH_IDLE;
      queued_q <= 1'b0;
      lost_q   <= '0;
      stall_q  <= '0;
      susp_q   <= '0;
    end else if (advance_i) begin
      burst_q  <= burst_d;
      resid_q  <= resid_d;
      cd_q     <= cd_d;
      pend_q   <= pend_d;
      phase_q  <= phase_d;
      queued_q <= queued_d;
      lost_q   <= lost_d;
      stall_q  <= stall_d;
      susp_q   <= susp_d;
    end else begin
      cd_q <= cd_eff;
    end
  end

  assign res_o.start_poll    = start;
  assign res_o.poll_count    = count;
  assign res_o.check_status  = check;
  assign res_o.release_all   = release_s;
  assign res_o.burst_now     = burst_d;
  assign res_o.phase_now     = phase_d;
  assign res_o.lost_ticks    = lost_d;
  assign res_o.stall_count   = stall_d;
  assign res_o.suspect_count = susp_d;

  a_burst_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q != '0 && burst_q <= apbc_pkg::BurstW'(apbc_pkg::CeilMax))
    else $error("burst out of range");
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= apbc_pkg::PendW'(apbc_pkg::StallLimit + 1))
    else $error("pending ticks beyond stall limit");
  a_queue_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(queued_q) |-> $past(advance_i && start))
    else $error("poll queued without a start request");

endmodule
